[rtl/history_excluding_random_selector_top_defines.svh]
// ----------------------------------------------------------------------------
// History-excluding random selector: assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef HISTORY_EXCLUDING_RANDOM_SELECTOR_TOP_DEFINES_SVH
`define HISTORY_EXCLUDING_RANDOM_SELECTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define HERS_ASSERT(lbl, clk_i, rstn_i, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
		else $error("hers assertion failed");
`define HERS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("hers assertion failed");
`else
`define HERS_ASSERT(lbl, clk_i, rstn_i, prop)
`define HERS_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

[rtl/hers_pkg.sv]
// ----------------------------------------------------------------------------
// hers_pkg
// Shared codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package hers_pkg;

	typedef enum logic [1:0] {
		FN_NEXT   = 2'd0,
		FN_PREV   = 2'd1,
		FN_SET    = 2'd2,
		FN_WEIGHT = 2'd3
	} func_t;

	localparam logic [1:0] MODE_SEQ      = 2'd0;
	localparam logic [1:0] MODE_SHUFFLE  = 2'd1;
	localparam logic [1:0] MODE_WEIGHTED = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_LOCK   = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;
	localparam logic [1:0] REG_WINDOW = 2'd3;

	typedef enum logic [2:0] {
		SRC_KEEP      = 3'd0,
		SRC_SET       = 3'd1,
		SRC_STEP_NEXT = 3'd2,
		SRC_STEP_PREV = 3'd3,
		SRC_PICK      = 3'd4,
		SRC_POP       = 3'd5
	} src_t;

	typedef struct packed {
		logic load;
		logic wr_weight;
		logic commit;
		src_t src;
		logic push;
		logic pop_rd;
		logic mod_init;
		logic mod_step;
		logic scan_init;
		logic scan_run;
		logic pass_init;
		logic pass1_run;
		logic draw;
		logic pass2_run;
	} hers_cmd_t;

	typedef struct packed {
		func_t      func;
		logic [1:0] mode;
		logic       locked;
		logic       n_zero;
		logic       fill_gt1;
		logic       mod_last;
		logic       scan_done;
		logic       pass_done;
		logic       sel_empty;
		logic       found;
	} hers_sts_t;

endpackage

[rtl/hers_ctrl.sv]
// ----------------------------------------------------------------------------
// hers_ctrl
// Command sequencer: decodes a command and steps the datapath through the
// remainder, pop, history scan, candidate passes, draw, weight write, commit.
// ----------------------------------------------------------------------------
`include "history_excluding_random_selector_top_defines.svh"

module hers_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output hers_pkg::hers_cmd_t cmd,
	input  hers_pkg::hers_sts_t sts
);
	import hers_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DISP  = 10'b0000000010,
		S_MOD   = 10'b0000000100,
		S_STEP  = 10'b0000001000,
		S_POP   = 10'b0000010000,
		S_SCAN  = 10'b0000100000,
		S_PASS1 = 10'b0001000000,
		S_DRAW  = 10'b0010000000,
		S_PASS2 = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.src = SRC_KEEP;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (sts.func)
					FN_WEIGHT: begin
						cmd.wr_weight = 1'b1;
					end
					FN_SET: begin
						if (!sts.n_zero) begin
							cmd.commit = 1'b1;
							cmd.src    = SRC_SET;
							cmd.push   = 1'b1;
						end
					end
					FN_NEXT: begin
						if (!sts.locked && !sts.n_zero) begin
							if (sts.mode == MODE_SEQ) begin
								cmd.mod_init = 1'b1;
								state_d      = S_MOD;
							end else if (sts.mode == MODE_SHUFFLE ||
								sts.mode == MODE_WEIGHTED) begin
								cmd.scan_init = 1'b1;
								state_d       = S_SCAN;
							end else begin
								cmd.commit = 1'b1;
								cmd.push   = 1'b1;
							end
						end
					end
					FN_PREV: begin
						if (!sts.locked && !sts.n_zero) begin
							if (sts.fill_gt1) begin
								cmd.pop_rd = 1'b1;
								state_d    = S_POP;
							end else begin
								cmd.mod_init = 1'b1;
								state_d      = S_MOD;
							end
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_d = S_STEP;
				end
			end
			S_STEP: begin
				cmd.commit = 1'b1;
				cmd.push   = 1'b1;
				cmd.src    = (sts.func == FN_PREV) ? SRC_STEP_PREV : SRC_STEP_NEXT;
				state_d    = S_DONE;
			end
			S_POP: begin
				cmd.commit = 1'b1;
				cmd.src    = SRC_POP;
				state_d    = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					cmd.pass_init = 1'b1;
					state_d       = S_PASS1;
				end
			end
			S_PASS1: begin
				cmd.pass1_run = 1'b1;
				if (sts.pass_done) begin
					state_d = S_DRAW;
				end
			end
			S_DRAW: begin
				cmd.draw = 1'b1;
				if (sts.sel_empty) begin
					cmd.commit = 1'b1;
					cmd.push   = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.pass_init = 1'b1;
					state_d       = S_PASS2;
				end
			end
			S_PASS2: begin
				cmd.pass2_run = 1'b1;
				if (sts.found || sts.pass_done) begin
					cmd.pass2_run = 1'b0;
					cmd.commit    = 1'b1;
					cmd.src       = SRC_PICK;
					cmd.push      = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`HERS_ASSERT(a_state_onehot, clk, arst_n, $onehot(state_q))
	`HERS_ASSERT_NEXT(a_start_dispatch, clk, arst_n, start && !busy, state_q == S_DISP)
	`HERS_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy && !done)
	`HERS_ASSERT(a_commit_single, clk, arst_n, $onehot0({cmd.commit, cmd.pop_rd, cmd.wr_weight}))

endmodule

[rtl/hers_dp.sv]
// ----------------------------------------------------------------------------
// hers_dp
// Datapath: configuration registers, history ring, weight memory, exclusion
// bits, remainder unit, candidate counters and the scaled draw.
// ----------------------------------------------------------------------------
`include "history_excluding_random_selector_top_defines.svh"

module hers_dp #(
	parameter int MAX_ENTRIES   = 64,
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	input  logic [1:0]          func,
	input  logic [5:0]          target_index,
	input  logic [15:0]         weight_value,
	input  logic [31:0]         random_value,
	input  hers_pkg::hers_cmd_t cmd,
	output hers_pkg::hers_sts_t sts,
	output logic [5:0]          current_index,
	output logic [8:0]          history_length
);
	import hers_pkg::*;

	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int CNW = $clog2(MAX_ENTRIES + 1);
	localparam int HW  = $clog2(HISTORY_DEPTH);
	localparam int FW  = $clog2(HISTORY_DEPTH + 1);
	localparam int TW  = 16 + CNW;
	localparam int MW  = $clog2(IW + 1);
	localparam int PW  = 32 + TW;

	logic [1:0]     mode_q;
	logic           locked_q;
	logic [6:0]     count_q;
	logic [8:0]     window_q;

	logic [1:0]     func_q;
	logic [5:0]     tgt_q;
	logic [15:0]    wv_q;
	logic [31:0]    r_q;
	logic [CNW-1:0] n_q;

	logic [HW-1:0]  head_q;
	logic [FW-1:0]  fill_q;
	logic [IW-1:0]  cur_q;
	logic           zv_q;

	logic [IW-1:0]  ring_mem [HISTORY_DEPTH];
	logic [IW-1:0]  rd_mem_s1;
	logic           rd_zero_s1;
	logic [IW-1:0]  ring_rd;
	logic [HW-1:0]  raddr;

	logic [15:0]    wt_mem [MAX_ENTRIES];
	logic [15:0]    w_s1;

	logic [MAX_ENTRIES-1:0] excl_q;
	logic [HW-1:0]  pos_q;
	logic [FW-1:0]  scan_left_q;
	logic           iss_s1;
	logic [IW-1:0]  i_s1;
	logic [CNW-1:0] pi_q;

	logic [CNW-1:0] rem_q;
	logic [IW-1:0]  sh_q;
	logic [MW-1:0]  mcnt_q;

	logic [CNW-1:0] cnt_a_q, cnt_b_q, seen_q;
	logic [TW-1:0]  tot_a_q, tot_b_q, run_q, key_q;
	logic           use_a_q, wt_eff_q, found_q;
	logic [IW-1:0]  pick_q;

	logic [HW-1:0]  head_inc, head_dec, pos_dec;
	logic [IW-1:0]  new_cur, set_val, next_val, prev_val;
	logic [31:0]    nm1;
	logic [CNW-1:0] m1;
	logic           tgt_ok;
	logic           pass_issue;
	logic           cand2, excl_bit;
	logic [TW-1:0]  run_n;
	logic [CNW:0]   mod_tmp;
	logic [CNW-1:0] cnt_sel;
	logic [TW-1:0]  tot_sel, mop;
	logic [PW-1:0]  prod;
	logic [31:0]    win;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_SEQ;
			locked_q <= 1'b0;
			count_q  <= '0;
			window_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_LOCK:   locked_q <= cfg_data[0];
				REG_COUNT:  count_q  <= cfg_data[6:0];
				REG_WINDOW: window_q <= cfg_data;
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	assign head_inc = (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? HW'(HISTORY_DEPTH - 1) : head_q - 1'b1;
	assign pos_dec  = (pos_q == '0) ? HW'(HISTORY_DEPTH - 1) : pos_q - 1'b1;
	assign tgt_ok   = (32'(tgt_q) < MAX_ENTRIES);
	assign raddr    = cmd.pop_rd ? head_dec : pos_q;
	assign ring_rd  = rd_zero_s1 ? '0 : rd_mem_s1;

	assign nm1      = 32'(n_q) - 32'd1;
	assign set_val  = IW'((32'(tgt_q) < nm1) ? 32'(tgt_q) : nm1);
	assign m1       = rem_q + 1'b1;
	assign next_val = (m1 == n_q) ? '0 : IW'(m1);
	assign prev_val = (rem_q == '0) ? IW'(nm1) : IW'(rem_q - 1'b1);

	always_comb begin
		case (cmd.src)
			SRC_SET:       new_cur = set_val;
			SRC_STEP_NEXT: new_cur = next_val;
			SRC_STEP_PREV: new_cur = prev_val;
			SRC_PICK:      new_cur = pick_q;
			SRC_POP:       new_cur = ring_rd;
			default:       new_cur = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			tgt_q  <= target_index;
			wv_q   <= weight_value;
			r_q    <= random_value;
			n_q    <= CNW'((32'(count_q) > MAX_ENTRIES) ? MAX_ENTRIES : 32'(count_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fill_q     <= FW'(1);
			cur_q      <= '0;
			zv_q       <= 1'b0;
			rd_zero_s1 <= 1'b0;
		end else begin
			rd_zero_s1 <= (raddr == '0) && !zv_q;
			if (cmd.commit) begin
				cur_q <= new_cur;
			end
			if (cmd.commit && cmd.push) begin
				head_q <= head_inc;
				if (32'(fill_q) < HISTORY_DEPTH) begin
					fill_q <= fill_q + 1'b1;
				end
				if (head_inc == '0) begin
					zv_q <= 1'b1;
				end
			end else if (cmd.pop_rd) begin
				head_q <= head_dec;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.push) begin
			ring_mem[head_inc] <= new_cur;
		end
		rd_mem_s1 <= ring_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_weight && tgt_ok) begin
			wt_mem[IW'(tgt_q)] <= wv_q;
		end
		w_s1 <= wt_mem[IW'(pi_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_init) begin
			rem_q  <= '0;
			sh_q   <= cur_q;
			mcnt_q <= MW'(IW);
		end else if (cmd.mod_step) begin
			rem_q  <= (mod_tmp >= {1'b0, n_q}) ? CNW'(mod_tmp - {1'b0, n_q}) : CNW'(mod_tmp);
			sh_q   <= sh_q << 1;
			mcnt_q <= mcnt_q - 1'b1;
		end
	end

	assign mod_tmp = {rem_q, sh_q[IW-1]};
	assign win     = (32'(window_q) < 32'(fill_q)) ? 32'(window_q) : 32'(fill_q);

	assign pass_issue = (pi_q != n_q) && (cmd.pass1_run || (cmd.pass2_run && !found_q));
	assign excl_bit   = excl_q[i_s1];
	assign cand2      = use_a_q ? !excl_bit : (i_s1 != cur_q);
	assign run_n      = run_q + TW'(w_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1      <= 1'b0;
			scan_left_q <= '0;
			pi_q        <= '0;
			found_q     <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				iss_s1      <= 1'b0;
				scan_left_q <= FW'(win);
			end else if (cmd.pass_init) begin
				iss_s1  <= 1'b0;
				pi_q    <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_run) begin
				iss_s1 <= (scan_left_q != '0);
				if (scan_left_q != '0) begin
					scan_left_q <= scan_left_q - 1'b1;
				end
			end else if (cmd.pass1_run || cmd.pass2_run) begin
				iss_s1 <= pass_issue;
				if (pass_issue) begin
					pi_q <= pi_q + 1'b1;
				end
				if (cmd.pass2_run && iss_s1 && cand2 && !found_q) begin
					if (wt_eff_q) begin
						found_q <= (run_n > key_q);
					end else begin
						found_q <= (TW'(seen_q) == key_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			pos_q  <= head_q;
			excl_q <= '0;
		end else if (cmd.scan_run) begin
			if (scan_left_q != '0) begin
				pos_q <= pos_dec;
			end
			if (iss_s1) begin
				excl_q[ring_rd] <= 1'b1;
			end
		end
		i_s1 <= IW'(pi_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_init) begin
			seen_q <= '0;
			run_q  <= '0;
			pick_q <= cur_q;
			if (cmd.scan_run) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				tot_a_q <= '0;
				tot_b_q <= '0;
			end
		end else if (cmd.pass1_run && iss_s1) begin
			if (!excl_bit) begin
				cnt_a_q <= cnt_a_q + 1'b1;
				tot_a_q <= tot_a_q + TW'(w_s1);
			end
			if (i_s1 != cur_q) begin
				cnt_b_q <= cnt_b_q + 1'b1;
				tot_b_q <= tot_b_q + TW'(w_s1);
			end
		end else if (cmd.pass2_run && iss_s1 && cand2 && !found_q) begin
			if (wt_eff_q) begin
				run_q <= run_n;
				if (run_n > key_q) begin
					pick_q <= i_s1;
				end
			end else begin
				seen_q <= seen_q + 1'b1;
				if (TW'(seen_q) == key_q) begin
					pick_q <= i_s1;
				end
			end
		end
	end

	assign cnt_sel = (cnt_a_q != '0) ? cnt_a_q : cnt_b_q;
	assign tot_sel = (mode_q != MODE_WEIGHTED) ? '0 : ((cnt_a_q != '0) ? tot_a_q : tot_b_q);
	assign mop     = (tot_sel != '0) ? tot_sel : TW'(cnt_sel);
	assign prod    = PW'(r_q) * PW'(mop);

	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			use_a_q  <= (cnt_a_q != '0);
			wt_eff_q <= (tot_sel != '0);
			key_q    <= prod[32 +: TW];
		end
	end

	always_comb begin
		sts           = '0;
		sts.func      = func_t'(func_q);
		sts.mode      = mode_q;
		sts.locked    = locked_q;
		sts.n_zero    = (n_q == '0);
		sts.fill_gt1  = (fill_q > FW'(1));
		sts.mod_last  = (mcnt_q == MW'(1));
		sts.scan_done = (scan_left_q == '0) && !iss_s1;
		sts.pass_done = (pi_q == n_q) && !iss_s1;
		sts.sel_empty = (cnt_sel == '0);
		sts.found     = found_q;
	end

	assign current_index  = 6'(cur_q);
	assign history_length = 9'(fill_q);

	`HERS_ASSERT(a_fill_range, clk, arst_n, (fill_q != '0) && (32'(fill_q) <= HISTORY_DEPTH))
	`HERS_ASSERT_NEXT(a_rem_below_n, clk, arst_n, cmd.mod_step, rem_q < n_q)
	`HERS_ASSERT(a_pop_nonempty, clk, arst_n, !cmd.pop_rd || (fill_q > FW'(1)))
	`HERS_ASSERT_NEXT(a_pick_in_range, clk, arst_n, cmd.commit && (cmd.src == SRC_PICK), 32'(cur_q) < 32'(n_q))

endmodule

[rtl/history_excluding_random_selector_top.sv]
// ----------------------------------------------------------------------------
// History-excluding random selector
// Sequential next and step-back use the remainder unit; pop reads the ring.
// Shuffle and weighted next scan the history window, count candidates in one
// pass and, if any remain, pick in a second, via the single ring and weight
// memory ports. One command at a time; done is a one-cycle strobe and the
// receiver cannot stall. Reset: history holds one entry 0, regs 0.
// ----------------------------------------------------------------------------
module history_excluding_random_selector_top #(
	parameter int MAX_ENTRIES   = 64,
	parameter int HISTORY_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [5:0]  target_index,
	input  logic [15:0] weight_value,
	input  logic [31:0] random_value,
	output logic        done,
	output logic [5:0]  current_index,
	output logic [8:0]  history_length
);
	import hers_pkg::*;

	hers_cmd_t cmd;
	hers_sts_t sts;

	hers_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	hers_dp #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.target_index   (target_index),
		.weight_value   (weight_value),
		.random_value   (random_value),
		.cmd            (cmd),
		.sts            (sts),
		.current_index  (current_index),
		.history_length (history_length)
	);

endmodule

[sim/history_excluding_random_selector_top_test.sv]
// ----------------------------------------------------------------------------
// History-excluding random selector testbench
// Drives next, previous, set and weight commands through the start/busy port
// and checks every done beat against an in-bench predictor of the history
// ring, the exclusion window and the weighted draw. Configuration is written
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module history_excluding_random_selector_top_test;
	import hers_pkg::*;

	localparam int ENTRIES = 64;
	localparam int DEPTH = 256;
	localparam int STALL_LIMIT = 20000;
	localparam int PHASES = 30;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		logic [5:0] cur;
		logic [8:0] len;
	} sel_result_t;

	typedef struct {
		func_t       fn;
		logic [5:0]  tgt;
		logic [15:0] wv;
		logic [31:0] rnd;
		bit          typed;
		logic [5:0]  cur;
		logic [8:0]  len;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [5:0]  target_index;
	logic [15:0] weight_value;
	logic [31:0] random_value;
	logic        done;
	logic [5:0]  current_index;
	logic [8:0]  history_length;

	// predictor state
	logic [1:0]  sel_mode;
	logic        sel_locked;
	logic [6:0]  sel_count;
	logic [8:0]  sel_window;
	logic [5:0]  ring [DEPTH];
	logic [7:0]  ring_head;
	logic [8:0]  ring_fill;
	logic [5:0]  cur_entry;
	logic [15:0] weights [ENTRIES];

	sel_result_t pending_results[$];
	cmd_row_t    rows[$];
	int          errors;
	int          idle_cycles;
	int          results_seen;
	bit          quiet;

	history_excluding_random_selector_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.func(func), .target_index(target_index),
		.weight_value(weight_value), .random_value(random_value),
		.done(done), .current_index(current_index),
		.history_length(history_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void add_row(cmd_row_t row);
		rows = {rows, row};
	endfunction

	function automatic void push_ring(logic [5:0] v);
		ring_head = ring_head + 8'd1;
		ring[ring_head] = v;
		if (ring_fill < DEPTH)
			ring_fill = ring_fill + 9'd1;
	endfunction

	function automatic bit in_window(int idx);
		int win;
		logic [7:0] pos;
		win = (sel_window < ring_fill) ? sel_window : ring_fill;
		pos = ring_head;
		for (int i = 0; i < win; i++) begin
			if (ring[pos] == idx)
				return 1'b1;
			pos = pos - 8'd1;
		end
		return 1'b0;
	endfunction

	function automatic logic [5:0] draw_entry(int n, logic [31:0] r, bit weighted);
		int cand [ENTRIES];
		int cnt;
		longint unsigned total;
		longint unsigned run;
		longint unsigned goal;
		cnt = 0;
		total = 0;
		run = 0;
		for (int i = 0; i < n; i++)
			if (!in_window(i)) begin
				cand[cnt] = i;
				cnt++;
			end
		if (cnt == 0)
			for (int i = 0; i < n; i++)
				if (i != cur_entry) begin
					cand[cnt] = i;
					cnt++;
				end
		if (cnt == 0)
			return cur_entry;
		if (weighted)
			for (int i = 0; i < cnt; i++)
				total += weights[cand[i]];
		if (total == 0)
			return 6'(cand[(longint'(r) * cnt) >> 32]);
		goal = (longint'(r) * total) >> 32;
		for (int i = 0; i < cnt; i++) begin
			run += weights[cand[i]];
			if (run > goal)
				return 6'(cand[i]);
		end
		return 6'(cand[cnt - 1]);
	endfunction

	function automatic sel_result_t apply_command(func_t fn, logic [5:0] tgt,
			logic [15:0] wv, logic [31:0] r);
		sel_result_t res;
		int n;
		n = (sel_count > ENTRIES) ? ENTRIES : sel_count;
		case (fn)
			FN_NEXT: begin
				if (!sel_locked && n != 0) begin
					if (sel_mode == MODE_SEQ)
						cur_entry = 6'((int'(cur_entry) + 1) % n);
					else if (sel_mode == MODE_SHUFFLE)
						cur_entry = draw_entry(n, r, 1'b0);
					else if (sel_mode == MODE_WEIGHTED)
						cur_entry = draw_entry(n, r, 1'b1);
					push_ring(cur_entry);
				end
			end
			FN_PREV: begin
				if (!sel_locked && n != 0) begin
					if (ring_fill > 1) begin
						ring_head = ring_head - 8'd1;
						ring_fill = ring_fill - 9'd1;
						cur_entry = ring[ring_head];
					end else begin
						cur_entry = 6'((int'(cur_entry) % n + n - 1) % n);
						push_ring(cur_entry);
					end
				end
			end
			FN_SET: begin
				if (n != 0) begin
					cur_entry = (tgt < n - 1) ? tgt : 6'(n - 1);
					push_ring(cur_entry);
				end
			end
			default: weights[tgt] = wv;
		endcase
		res.cur = cur_entry;
		res.len = ring_fill;
		return res;
	endfunction

	// hold start across beats; lower it only ahead of a gap
	task automatic issue_command(func_t fn, logic [5:0] tgt, logic [15:0] wv,
			logic [31:0] r, bit typed, logic [5:0] tcur, logic [8:0] tlen);
		int gap;
		sel_result_t res;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= fn;
		target_index <= tgt;
		weight_value <= wv;
		random_value <= r;
		do @(posedge clk); while (busy);
		res = apply_command(fn, tgt, wv, r);
		if (typed) begin
			res.cur = tcur;
			res.len = tlen;
		end
		pending_results = {pending_results, res};
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] val);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE:   sel_mode = val[1:0];
			REG_LOCK:   sel_locked = val[0];
			REG_COUNT:  sel_count = val[6:0];
			default:    sel_window = val;
		endcase
		@(posedge clk);
	endtask

	task automatic set_phase(logic [1:0] m, logic l, logic [6:0] c, logic [8:0] w);
		write_reg(REG_MODE, {7'd0, m});
		write_reg(REG_LOCK, {8'd0, l});
		write_reg(REG_COUNT, {2'd0, c});
		write_reg(REG_WINDOW, w);
	endtask

	function automatic logic [31:0] pick_random();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0, 1: return 16'h0;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	always @(posedge clk) begin
		if (done || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (done) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result cur=%0d len=%0d", $time,
					current_index, history_length);
				errors = errors + 1;
			end else begin
				if (current_index !== pending_results[0].cur) begin
					$display("%0t: current_index expected %0d actual %0d", $time,
						pending_results[0].cur, current_index);
					errors = errors + 1;
				end
				if (history_length !== pending_results[0].len) begin
					$display("%0t: history_length expected %0d actual %0d", $time,
						pending_results[0].len, history_length);
					errors = errors + 1;
				end
				pending_results.delete(0);
			end
		end
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int split;
		func_t fn;
		logic [6:0] cnt;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		func = FN_NEXT;
		target_index = '0;
		weight_value = '0;
		random_value = '0;
		errors = 0;
		idle_cycles = 0;
		results_seen = 0;
		quiet = 1'b0;
		sel_mode = MODE_SEQ;
		sel_locked = 1'b0;
		sel_count = '0;
		sel_window = '0;
		for (int i = 0; i < DEPTH; i++) ring[i] = '0;
		ring_head = '0;
		ring_fill = 9'd1;
		cur_entry = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// with no entries every move is dropped
		add_row('{FN_NEXT, 6'd0, 16'd0, 32'h0, 1'b1, 6'd0, 9'd1});
		add_row('{FN_PREV, 6'd0, 16'd0, 32'h0, 1'b1, 6'd0, 9'd1});
		add_row('{FN_SET, 6'd63, 16'd0, 32'hFFFF_FFFF, 1'b1, 6'd0, 9'd1});
		add_row('{FN_WEIGHT, 6'd63, 16'hFFFF, 32'h0, 1'b1, 6'd0, 9'd1});
		split = rows.size();
		add_row('{FN_SET, 6'd63, 16'd0, 32'h0, 1'b1, 6'd63, 9'd2});
		add_row('{FN_NEXT, 6'd0, 16'd0, 32'h0, 1'b1, 6'd0, 9'd3});
		add_row('{FN_SET, 6'd0, 16'd0, 32'h0, 1'b1, 6'd0, 9'd4});
		add_row('{FN_PREV, 6'd0, 16'd0, 32'h0, 1'b1, 6'd0, 9'd3});
		add_row('{FN_PREV, 6'd0, 16'd0, 32'h0, 1'b0, 6'd0, 9'd0});
		add_row('{FN_PREV, 6'd0, 16'd0, 32'h0, 1'b0, 6'd0, 9'd0});
		add_row('{FN_PREV, 6'd0, 16'd0, 32'h0, 1'b0, 6'd0, 9'd0});
		add_row('{FN_WEIGHT, 6'd0, 16'h0, 32'h0, 1'b0, 6'd0, 9'd0});
		add_row('{FN_WEIGHT, 6'd21, 16'hAAAA, 32'h0, 1'b0, 6'd0, 9'd0});
		add_row('{FN_WEIGHT, 6'd42, 16'h5555, 32'h0, 1'b0, 6'd0, 9'd0});

		for (int i = 0; i < split; i++)
			issue_command(rows[i].fn, rows[i].tgt, rows[i].wv, rows[i].rnd,
				rows[i].typed, rows[i].cur, rows[i].len);

		// write every weight before any weighted draw can read it
		write_reg(REG_COUNT, 9'd64);
		for (int i = 0; i < ENTRIES; i++)
			issue_command(FN_WEIGHT, 6'(i), pick_weight(), $urandom, 1'b0, '0, '0);
		for (int i = split; i < rows.size(); i++)
			issue_command(rows[i].fn, rows[i].tgt, rows[i].wv, rows[i].rnd,
				rows[i].typed, rows[i].cur, rows[i].len);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_phase(MODE_SHUFFLE, 1'b0, 7'd64, 9'd256);
				1: set_phase(MODE_WEIGHTED, 1'b0, 7'd64, 9'd511);
				2: set_phase(MODE_SHUFFLE, 1'b0, 7'd2, 9'd1);
				3: set_phase(MODE_WEIGHTED, 1'b0, 7'd3, 9'd0);
				4: set_phase(2'd3, 1'b0, 7'd5, 9'd3);
				5: set_phase(MODE_SEQ, 1'b1, 7'd127, 9'd2);
				6: set_phase(MODE_SEQ, 1'b0, 7'd1, 9'd0);
				7: set_phase(MODE_WEIGHTED, 1'b0, 7'd100, 9'd40);
				8: set_phase(MODE_SEQ, 1'b0, 7'd0, 9'd8);
				default: begin
					cnt = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
						: 7'($urandom_range(1, 8));
					set_phase(2'($urandom_range(0, 3)), $urandom_range(0, 5) == 0, cnt,
						($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 6)));
				end
			endcase
			quiet = (p >= PHASES - 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 9))
					0, 1: fn = FN_PREV;
					2: fn = FN_SET;
					3: fn = FN_WEIGHT;
					default: fn = FN_NEXT;
				endcase
				issue_command(fn, 6'($urandom), pick_weight(), pick_random(),
					1'b0, '0, '0);
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		$display("Covered %0d commands over %0d register settings, all modes and lock.",
			results_seen, PHASES + 2);
		$display("History wrap, exclusion fallback and weighted draws were exercised.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/hers_pkg.sv
rtl/hers_ctrl.sv
rtl/hers_dp.sv
rtl/history_excluding_random_selector_top.sv
sim/history_excluding_random_selector_top_test.sv
